### rtl/ktrp_pkg.sv
// Shared types and constants for the keyed theta round permutation.
// Used by ktrp_cell and keyed_theta_round_permutation; no dependencies.
`default_nettype none

package ktrp_pkg;

    localparam int          WORD_W     = 32;
    localparam int          WORD_COUNT = 4;
    localparam int          CFG_IDX_W  = 2;
    localparam logic [7:0]  RC_START   = 8'h80;
    localparam logic [7:0]  RC_POLY    = 8'h1b;

    typedef logic [WORD_COUNT-1:0][WORD_W-1:0] t_state;

    typedef struct packed {
        logic [WORD_W-1:0] word_in_0;
        logic [WORD_W-1:0] word_in_1;
        logic [WORD_W-1:0] word_in_2;
        logic [WORD_W-1:0] word_in_3;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] word_out_0;
        logic [WORD_W-1:0] word_out_1;
        logic [WORD_W-1:0] word_out_2;
        logic [WORD_W-1:0] word_out_3;
    } t_out_item;

    // Round constant of round r: RC_START doubled r times in GF(2^8).
    function automatic logic [7:0] round_const(int r);
        logic [7:0] rc;
        rc = RC_START;
        for (int k = 0; k < r; k++) begin
            rc = rc[7] ? ({rc[6:0], 1'b0} ^ RC_POLY) : {rc[6:0], 1'b0};
        end
        return rc;
    endfunction

    function automatic logic [WORD_W-1:0] spread(logic [WORD_W-1:0] t);
        return t ^ {t[7:0], t[WORD_W-1:8]} ^ {t[23:0], t[WORD_W-1:24]};
    endfunction

endpackage

`default_nettype wire

### rtl/ktrp_cell.sv
// One round of the permutation with its own pipeline register.
// Depends on ktrp_pkg for the state type and the spread function.
`default_nettype none

module ktrp_cell #(
    parameter logic [7:0] RC = 8'h80
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire ktrp_pkg::t_state i_in_state,
    input  wire ktrp_pkg::t_state i_key,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output ktrp_pkg::t_state     o_out_state
);

    logic             r_valid;
    ktrp_pkg::t_state r_state;
    ktrp_pkg::t_state n_state;
    logic [ktrp_pkg::WORD_W-1:0] w_t0;
    logic [ktrp_pkg::WORD_W-1:0] w_t1;
    ktrp_pkg::t_state w_mid;

    always_comb begin
        w_mid    = i_in_state;
        w_mid[0] = w_mid[0] ^ {{(ktrp_pkg::WORD_W-8){1'b0}}, RC};
        w_t0     = ktrp_pkg::spread(w_mid[0] ^ w_mid[2]);
        w_mid[1] = w_mid[1] ^ w_t0;
        w_mid[3] = w_mid[3] ^ w_t0;
        w_mid    = w_mid ^ i_key;
        w_t1     = ktrp_pkg::spread(w_mid[1] ^ w_mid[3]);
        n_state    = w_mid;
        n_state[0] = w_mid[0] ^ w_t1;
        n_state[2] = w_mid[2] ^ w_t1;
    end

    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_state = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/keyed_theta_round_permutation.sv
// Top level: key registers and a chain of ROUND_COUNT round cells.
// Depends on ktrp_pkg and ktrp_cell.
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_ready  o_out_data (t_out_item)
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// There is one cell register per round; one transfer per cycle is sustained
// while the output is ready. Reset clears the cell valid bits and the key.
// A stalled output holds the last cell; earlier cells keep filling bubbles,
// so input is refused only when every cell holds an item.
`default_nettype none

module keyed_theta_round_permutation #(
    parameter int ROUND_COUNT = 17
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire ktrp_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output ktrp_pkg::t_out_item                o_out_data,
    input  wire                                i_cfg_we,
    input  wire  [ktrp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [ktrp_pkg::WORD_W-1:0]        i_cfg_data
);

    ktrp_pkg::t_state r_key;
    ktrp_pkg::t_state w_state [ROUND_COUNT+1];
    logic [ROUND_COUNT:0] w_valid;
    logic [ROUND_COUNT:0] w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign w_valid[0]    = i_in_valid;
    assign o_in_ready    = w_ready[0];
    assign w_state[0][0] = i_in_data.word_in_0;
    assign w_state[0][1] = i_in_data.word_in_1;
    assign w_state[0][2] = i_in_data.word_in_2;
    assign w_state[0][3] = i_in_data.word_in_3;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        ktrp_cell #(
            .RC(ktrp_pkg::round_const(g))
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_in_valid  (w_valid[g]),
            .o_in_ready  (w_ready[g]),
            .i_in_state  (w_state[g]),
            .i_key       (r_key),
            .o_out_valid (w_valid[g+1]),
            .i_out_ready (w_ready[g+1]),
            .o_out_state (w_state[g+1])
        );
    end

    assign w_ready[ROUND_COUNT] = i_out_ready;
    assign o_out_valid          = w_valid[ROUND_COUNT];
    assign o_out_data.word_out_0 = w_state[ROUND_COUNT][0];
    assign o_out_data.word_out_1 = w_state[ROUND_COUNT][1];
    assign o_out_data.word_out_2 = w_state[ROUND_COUNT][2];
    assign o_out_data.word_out_3 = w_state[ROUND_COUNT][3];

    // an empty last cell lets the whole chain move
    a_ready_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready
    ) else $error("input refused while output cell empty");

    // occupancy follows transfers in and out
    a_occupancy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            $countones(w_valid[ROUND_COUNT:1]) ==
            $countones($past(w_valid[ROUND_COUNT:1]))
            + ($past(i_in_valid && o_in_ready) ? 1 : 0)
            - ($past(o_out_valid && i_out_ready) ? 1 : 0)
    ) else $error("items lost or duplicated in cell chain");

endmodule

`default_nettype wire
